// ----- hw/rtl/lpe_pkg.sv -----
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types and constants for the Legendre polynomial evaluator.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int LPE_MAX_ORDER = 32;
  localparam int X_W           = 18;   // Q1.16 point and result
  localparam int P_W           = 20;   // unsaturated recurrence values
  localparam int ORD_W         = 6;    // config register width
  localparam int N_W           = 7;    // effective degree, clamped to MAX_ORDER

  localparam logic signed [X_W-1:0] ONE_Q16  = 18'sd65536;
  localparam logic signed [X_W-1:0] MONE_Q16 = -18'sd65536;

  // one word travelling down the step chain
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic signed [X_W-1:0] x;
    logic signed [P_W-1:0] p0;
    logic signed [P_W-1:0] p1;
    logic signed [P_W-1:0] res;
  } lpe_item_t;

endpackage

// ----- hw/rtl/lpe_step.sv -----
// ----------------------------------------------------------------------------
// lpe_step
// One recurrence step P(i) = ((2i-1) x P(i-1) - (i-1) P(i-2)) / i in three
// register stages: product, numerator with rounding, reciprocal division.
// ----------------------------------------------------------------------------
module lpe_step import lpe_pkg::*; #(
  parameter int STEP = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [N_W-1:0] n_eff,
  input  lpe_item_t      item_in,
  output lpe_item_t      item_out
);

  localparam logic signed [45:0] K_A   = 46'(2*STEP-1);
  localparam logic signed [45:0] K_B   = 46'(STEP-1);
  localparam logic [45:0]        RND   = 46'(STEP) << 15;
  localparam logic [31:0]        RECIP = 32'(((64'd1 << 32) + 64'(STEP) - 64'd1) / 64'(STEP));
  localparam logic [N_W-1:0]     STEP_N = N_W'(STEP);

  // stage a: x * P(i-1)
  logic                  va_r, la_r;
  logic signed [X_W-1:0] xa_r;
  logic signed [P_W-1:0] p0a_r, p1a_r, resa_r;
  logic signed [37:0]    proda_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      la_r    <= item_in.last;
      xa_r    <= item_in.x;
      p0a_r   <= item_in.p0;
      p1a_r   <= item_in.p1;
      resa_r  <= item_in.res;
      proda_r <= 38'(item_in.x) * 38'(item_in.p1);
    end
  end

  // stage b: numerator, magnitude and half-divisor rounding
  logic signed [45:0] num;
  logic [45:0]        mag;
  logic [45:0]        madd;

  assign num  = 46'(proda_r) * K_A - ((46'(p0a_r) * K_B) <<< 16);
  assign mag  = num[45] ? 46'(-num) : 46'(num);
  assign madd = mag + RND;

  logic                  vb_r, lb_r, negb_r;
  logic signed [X_W-1:0] xb_r;
  logic signed [P_W-1:0] p1b_r, resb_r;
  logic [25:0]           tb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lb_r   <= la_r;
      xb_r   <= xa_r;
      p1b_r  <= p1a_r;
      resb_r <= resa_r;
      negb_r <= num[45];
      tb_r   <= madd[41:16];
    end
  end

  // stage c: divide by the step index through its reciprocal
  logic                  vc_r, lc_r, negc_r;
  logic signed [X_W-1:0] xc_r;
  logic signed [P_W-1:0] p1c_r, resc_r;
  logic [57:0]           qm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lc_r   <= lb_r;
      xc_r   <= xb_r;
      p1c_r  <= p1b_r;
      resc_r <= resb_r;
      negc_r <= negb_r;
      qm_r   <= 58'(tb_r) * 58'(RECIP);
    end
  end

  // signed quotient and hand-off to the next step
  logic signed [P_W-1:0] q;
  logic signed [P_W-1:0] pn;

  assign q  = $signed(qm_r[32+P_W-1:32]);
  assign pn = negc_r ? -q : q;

  always_comb begin
    item_out.valid = vc_r;
    item_out.last  = lc_r;
    item_out.x     = xc_r;
    item_out.p0    = p1c_r;
    item_out.p1    = pn;
    item_out.res   = (n_eff == STEP_N) ? pn : resc_r;
  end

endmodule

// ----- hw/rtl/legendre_polynomial_eval.sv -----
// ----------------------------------------------------------------------------
// legendre_polynomial_eval
// Streams points x and returns P_n(x), n from cfg, signed Q1.16, saturated.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  in      | in_valid in_ready in_x_value in_last_point | word in
//  out     | out_valid out_ready out_p_value out_last_out | word out
//  cfg     | cfg_we cfg_data                      | register write
//
// One word enters per cycle while in_ready is high. It passes the entry stage,
// MAX_ORDER-1 recurrence steps of three stages each, and the output register.
// Every word runs the whole chain; the result is picked at step n, or at entry for n < 2.
// A stalled output register freezes the whole chain; nothing is lost.
// Reset clears the valid bits and sets the degree to zero.
module legendre_polynomial_eval import lpe_pkg::*; #(
  parameter int MAX_ORDER = LPE_MAX_ORDER
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [X_W-1:0] in_x_value,
  input  logic                  in_last_point,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [X_W-1:0] out_p_value,
  output logic                  out_last_out,
  input  logic                  cfg_we,
  input  logic [ORD_W-1:0]      cfg_data
);

  // degree register
  logic [ORD_W-1:0] poly_order_r;
  logic [N_W-1:0]   n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_order_r <= '0;
    end else if (cfg_we) begin
      poly_order_r <= cfg_data;
    end
  end

  assign n_eff = (N_W'(poly_order_r) > N_W'(MAX_ORDER)) ? N_W'(MAX_ORDER)
                                                       : N_W'(poly_order_r);

  // chain advances whenever the output register can move
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // entry stage: clamp x and seed P0, P1
  logic signed [X_W-1:0] x_cl;
  assign x_cl = (in_x_value > ONE_Q16)  ? ONE_Q16 :
                (in_x_value < MONE_Q16) ? MONE_Q16 : in_x_value;

  lpe_item_t chain [MAX_ORDER];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0].valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].last <= in_last_point;
      chain[0].x    <= x_cl;
      chain[0].p0   <= P_W'(ONE_Q16);
      chain[0].p1   <= P_W'(x_cl);
      chain[0].res  <= (n_eff == '0) ? P_W'(ONE_Q16) : P_W'(x_cl);
    end
  end

  // recurrence steps 2 .. MAX_ORDER
  for (genvar g = 2; g <= MAX_ORDER; g++) begin : g_step
    lpe_step #(.STEP(g)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .n_eff    (n_eff),
      .item_in  (chain[g-2]),
      .item_out (chain[g-1])
    );
  end

  // output register with saturation
  lpe_item_t             fin;
  logic signed [X_W-1:0] sat;
  logic signed [X_W-1:0] p_value_r;
  logic                  last_r;

  assign fin = chain[MAX_ORDER-1];
  assign sat = (fin.res > P_W'(ONE_Q16))  ? ONE_Q16 :
               (fin.res < P_W'(MONE_Q16)) ? MONE_Q16 : X_W'(fin.res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_value_r <= sat;
      last_r    <= fin.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_p_value  = p_value_r;
  assign out_last_out = last_r;

endmodule

// ----- hw/rtl/lpe_checker.sv -----
// ----------------------------------------------------------------------------
// lpe_checker
// Port-level checks for the Legendre polynomial evaluator, bound to the top.
// ----------------------------------------------------------------------------
module lpe_checker import lpe_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic signed [X_W-1:0] out_p_value
);

  // stalled word holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_p_value))
    else $error("output word changed while stalled");

  // result always saturated to [-1, 1]
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_p_value <= ONE_Q16) && (out_p_value >= MONE_Q16))
    else $error("result out of range");

  // a free output never blocks the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled with output ready");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("word present after reset");

endmodule

bind legendre_polynomial_eval lpe_checker u_lpe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_p_value (out_p_value)
);
